// File: rtl/rcfs_pkg.sv
package rcfs_pkg;

    // chroma shift distance in pixels
    localparam int SHIFT  = 7;
    localparam int HELD_W = $clog2(SHIFT + 1);
    localparam int IDX_W  = (SHIFT > 1) ? $clog2(SHIFT) : 1;

    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int CFG_W  = 2;

    // configuration register indexes
    localparam logic CFG_FILTER = 1'b0;
    localparam logic CFG_EFFECT = 1'b1;

    // filter modes, the fourth code behaves as none
    localparam logic [1:0] FILT_NONE  = 2'd0;
    localparam logic [1:0] FILT_GRAY  = 2'd1;
    localparam logic [1:0] FILT_SEPIA = 2'd2;

    localparam logic EFF_NONE  = 1'b0;
    localparam logic EFF_SHIFT = 1'b1;

    // sepia matrix, Q0.16
    localparam logic [15:0] SEP_RR = 16'd20972;
    localparam logic [15:0] SEP_RG = 16'd28836;
    localparam logic [15:0] SEP_RB = 16'd15729;
    localparam logic [15:0] SEP_GR = 16'd23593;
    localparam logic [15:0] SEP_GG = 16'd23593;
    localparam logic [15:0] SEP_GB = 16'd10486;
    localparam logic [15:0] SEP_BR = 16'd18350;
    localparam logic [15:0] SEP_BG = 16'd18612;
    localparam logic [15:0] SEP_BB = 16'd9175;

    // floor(s / 3) = (s * 683) >> 11, exact for s below 2048
    localparam logic [9:0] GRAY_RECIP = 10'd683;
    localparam int         GRAY_SHR   = 11;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_ACT  = 5'b01000,
        S_TAIL = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        EMIT_HEAD    = 2'd0,
        EMIT_PX      = 2'd1,
        EMIT_COMBINE = 2'd2
    } t_emit_sel;

    typedef struct packed {
        logic              load_in;
        logic              mul;
        logic              sum;
        logic [1:0]        filter_mode;
        logic              emit;
        t_emit_sel         emit_sel;
        logic              emit_last;
        logic              shift;
        logic              push;
        logic [IDX_W-1:0]  push_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic row_end;
    } t_dp_status;

endpackage

// File: rtl/rcfs_datapath.sv
module rcfs_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rcfs_pkg::t_dp_cmd        i_cmd,
    output rcfs_pkg::t_dp_status     o_status,
    input  logic [rcfs_pkg::CH_W-1:0] i_in_red,
    input  logic [rcfs_pkg::CH_W-1:0] i_in_green,
    input  logic [rcfs_pkg::CH_W-1:0] i_in_blue,
    input  logic                     i_row_end,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [rcfs_pkg::CH_W-1:0] o_out_red,
    output logic [rcfs_pkg::CH_W-1:0] o_out_green,
    output logic [rcfs_pkg::CH_W-1:0] o_out_blue,
    output logic                     o_out_row_end
);

    function automatic logic [7:0] sat8(input logic [9:0] v);
        logic [7:0] res;
        res = (v > 10'd255) ? 8'd255 : v[7:0];
        return res;
    endfunction

    logic [7:0]  r_red, r_green, r_blue;
    logic        r_row_end;
    logic [23:0] r_prod [9];
    logic [9:0]  r_sum3;
    logic [23:0] r_px;
    logic [23:0] r_line [rcfs_pkg::SHIFT];
    logic [23:0] n_line [rcfs_pkg::SHIFT];
    logic        r_out_valid;
    logic [23:0] r_out_px;
    logic        r_out_last;

    logic [25:0] sep_r, sep_g, sep_b;
    logic [19:0] gray_full;
    logic [7:0]  gray;
    logic [23:0] n_px;
    logic [23:0] emit_px;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_red     <= i_in_red;
            r_green   <= i_in_green;
            r_blue    <= i_in_blue;
            r_row_end <= i_row_end;
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod[0] <= rcfs_pkg::SEP_RR * r_red;
            r_prod[1] <= rcfs_pkg::SEP_RG * r_green;
            r_prod[2] <= rcfs_pkg::SEP_RB * r_blue;
            r_prod[3] <= rcfs_pkg::SEP_GR * r_red;
            r_prod[4] <= rcfs_pkg::SEP_GG * r_green;
            r_prod[5] <= rcfs_pkg::SEP_GB * r_blue;
            r_prod[6] <= rcfs_pkg::SEP_BR * r_red;
            r_prod[7] <= rcfs_pkg::SEP_BG * r_green;
            r_prod[8] <= rcfs_pkg::SEP_BB * r_blue;
            r_sum3    <= {2'b00, r_red} + {2'b00, r_green} + {2'b00, r_blue};
        end
    end

    // sum stage, floor then saturate
    always_comb begin
        sep_r = {2'b00, r_prod[0]} + {2'b00, r_prod[1]} + {2'b00, r_prod[2]};
        sep_g = {2'b00, r_prod[3]} + {2'b00, r_prod[4]} + {2'b00, r_prod[5]};
        sep_b = {2'b00, r_prod[6]} + {2'b00, r_prod[7]} + {2'b00, r_prod[8]};
        gray_full = r_sum3 * rcfs_pkg::GRAY_RECIP;
        gray = gray_full[rcfs_pkg::GRAY_SHR +: 8];
        case (i_cmd.filter_mode)
            rcfs_pkg::FILT_GRAY:  n_px = {gray, gray, gray};
            rcfs_pkg::FILT_SEPIA: n_px = {sat8(sep_r[25:16]), sat8(sep_g[25:16]),
                                          sat8(sep_b[25:16])};
            default:              n_px = {r_red, r_green, r_blue};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_px <= n_px;
        end
    end

    // delay line: head at index 0, writes at the fill position
    always_comb begin
        for (int i = 0; i < rcfs_pkg::SHIFT; i++) begin
            n_line[i] = r_line[i];
        end
        if (i_cmd.shift) begin
            for (int i = 0; i < rcfs_pkg::SHIFT - 1; i++) begin
                n_line[i] = r_line[i + 1];
            end
        end
        if (i_cmd.push) begin
            n_line[i_cmd.push_idx] = r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < rcfs_pkg::SHIFT; i++) begin
            r_line[i] <= n_line[i];
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            rcfs_pkg::EMIT_PX:      emit_px = r_px;
            rcfs_pkg::EMIT_COMBINE: emit_px = {r_line[0][23:16], r_px[15:0]};
            default:                emit_px = r_line[0];
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_px   <= emit_px;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_status.row_end  = r_row_end;

    assign o_valid       = r_out_valid;
    assign o_out_red     = r_out_px[23:16];
    assign o_out_green   = r_out_px[15:8];
    assign o_out_blue    = r_out_px[7:0];
    assign o_out_row_end = r_out_last;

endmodule

// File: rtl/rcfs_ctrl.sv
module rcfs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [rcfs_pkg::CFG_W-1:0] i_cfg_data,
    input  rcfs_pkg::t_dp_status       i_status,
    output rcfs_pkg::t_dp_cmd          o_cmd
);

    rcfs_pkg::t_state                r_state, n_state;
    logic [rcfs_pkg::HELD_W-1:0]     r_held, n_held;
    logic [1:0]                      r_filter_mode;
    logic                            r_effect_mode;
    logic                            full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= rcfs_pkg::FILT_NONE;
            r_effect_mode <= rcfs_pkg::EFF_NONE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rcfs_pkg::CFG_FILTER) begin
                r_filter_mode <= i_cfg_data[1:0];
            end else begin
                r_effect_mode <= i_cfg_data[0];
            end
        end
    end

    assign full    = (r_held == rcfs_pkg::HELD_W'(rcfs_pkg::SHIFT));
    assign o_ready = (r_state == rcfs_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        o_cmd   = '0;
        o_cmd.filter_mode = r_filter_mode;
        o_cmd.emit_sel    = rcfs_pkg::EMIT_HEAD;
        case (r_state)
            rcfs_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = rcfs_pkg::S_MUL;
                end
            end
            rcfs_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = rcfs_pkg::S_SUM;
            end
            rcfs_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = rcfs_pkg::S_ACT;
            end
            rcfs_pkg::S_ACT: begin
                if (r_effect_mode == rcfs_pkg::EFF_NONE) begin
                    // drain what a cleared effect left behind, then the pixel
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (r_held != '0) begin
                            o_cmd.shift = 1'b1;
                            n_held = r_held - 1'b1;
                        end else begin
                            o_cmd.emit_sel  = rcfs_pkg::EMIT_PX;
                            o_cmd.emit_last = i_status.row_end;
                            n_state = rcfs_pkg::S_IDLE;
                        end
                    end
                end else if (full) begin
                    if (i_status.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = rcfs_pkg::EMIT_COMBINE;
                        o_cmd.shift    = 1'b1;
                        o_cmd.push     = 1'b1;
                        o_cmd.push_idx = rcfs_pkg::IDX_W'(rcfs_pkg::SHIFT - 1);
                        n_state = i_status.row_end ? rcfs_pkg::S_TAIL : rcfs_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_idx = r_held[rcfs_pkg::IDX_W-1:0];
                    n_held = r_held + 1'b1;
                    n_state = i_status.row_end ? rcfs_pkg::S_TAIL : rcfs_pkg::S_IDLE;
                end
            end
            rcfs_pkg::S_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.shift     = 1'b1;
                    o_cmd.emit_last = (r_held == rcfs_pkg::HELD_W'(1));
                    n_held = r_held - 1'b1;
                    if (r_held == rcfs_pkg::HELD_W'(1)) begin
                        n_state = rcfs_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rcfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcfs_pkg::S_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= rcfs_pkg::HELD_W'(rcfs_pkg::SHIFT))
        else $error("delay line count above shift");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result written over a waiting result");

    a_tail_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rcfs_pkg::S_TAIL |-> r_held != '0)
        else $error("row end flush with empty delay line");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state == rcfs_pkg::S_MUL)
        else $error("accepted item did not start filtering");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last && r_state == rcfs_pkg::S_TAIL) |=> r_held == '0)
        else $error("row end marked while pixels still held");
`endif

endmodule

// File: rtl/rgb_color_filter_shift.sv
// channel  | handshake           | payload
// -------- | ------------------- | ------------------------------------------------
// input    | i_valid / o_ready   | i_in_red, i_in_green, i_in_blue, i_row_end
// output   | o_valid / i_ready   | o_out_red, o_out_green, o_out_blue, o_out_row_end
// config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// one item at a time: after accept the controller steps through the multiply,
// sum and act states before it is ready again, and also flushes every pixel held
// in the 7-entry delay line (at row end, or after the shift effect is turned off)
// through the single output register. synchronous active-low reset clears the
// controller, the delay line count, the output valid and both configuration registers.
// a stalled output holds the controller in place; input stays blocked until
// every result of the item has been loaded into the output register.
module rgb_color_filter_shift (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rcfs_pkg::CH_W-1:0]  i_in_red,
    input  logic [rcfs_pkg::CH_W-1:0]  i_in_green,
    input  logic [rcfs_pkg::CH_W-1:0]  i_in_blue,
    input  logic                       i_row_end,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rcfs_pkg::CH_W-1:0]  o_out_red,
    output logic [rcfs_pkg::CH_W-1:0]  o_out_green,
    output logic [rcfs_pkg::CH_W-1:0]  o_out_blue,
    output logic                       o_out_row_end,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [rcfs_pkg::CFG_W-1:0] i_cfg_data
);

    rcfs_pkg::t_dp_cmd    cmd;
    rcfs_pkg::t_dp_status status;

    rcfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rcfs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_row_end     (i_row_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_row_end (o_out_row_end)
    );

endmodule
